[rtl/min_partition_difference_macros.svh]
// ----------------------------------------------------------------------------
// min_partition_difference assertion macros
// concurrent check wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef MIN_PARTITION_DIFFERENCE_MACROS_SVH
`define MIN_PARTITION_DIFFERENCE_MACROS_SVH

`ifndef SYNTHESIS
`define MPD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("min_partition_difference check failed");
`define MPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("min_partition_difference check failed");
`else
`define MPD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/mpd_pkg.sv]
// ----------------------------------------------------------------------------
// mpd_pkg
// shared widths and bit helpers for the partition difference block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

  localparam int ELEM_W = 13;
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  typedef logic [WORD_W-1:0] word_t;

  // index of the highest set bit, zero for an empty word
  function automatic logic [BIT_W-1:0] msb_index(input word_t w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[rtl/mpd_ram.sv]
// ----------------------------------------------------------------------------
// mpd_ram
// one write port, two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpd_ram #(
  parameter int DEPTH = 33,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire mpd_pkg::word_t    wdata,
  input  wire logic [AW-1:0]     raddr_a,
  input  wire logic [AW-1:0]     raddr_b,
  output mpd_pkg::word_t         rdata_a,
  output mpd_pkg::word_t         rdata_b
);
  import mpd_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[rtl/min_partition_difference.sv]
// ----------------------------------------------------------------------------
// min_partition_difference
// subset-sum bitset in a 64-bit word memory, minimum two-way split per set
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, element_value, last_element | into block
//  out     | out_valid, out_stall, min_difference, overflow  | out of block
//
//  a nonzero element that fits the bitset runs a shift pass from the top word down,
//  one memory word read-or-written per cycle; other elements leave the block idle
//  a last element adds a descending word search unless the total overflowed,
//  a result load step that waits while the previous result is stalled,
//  then a clear sweep over every memory word
//  after reset the same clear sweep runs before the first transfer
//  a pending result holds while the next set streams in; only the next result
//  waits for out_stall to drop
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "min_partition_difference_macros.svh"

module min_partition_difference #(
  parameter int HALF_SUM_LIMIT = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mpd_pkg::ELEM_W-1:0]    element_value,
  input  wire logic                          last_element,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mpd_pkg::ELEM_W-1:0]         min_difference,
  output logic                               overflow
);
  import mpd_pkg::*;

  localparam int WORDS    = (HALF_SUM_LIMIT + 1 + WORD_W - 1) / WORD_W;
  localparam int TOP_BITS = (HALF_SUM_LIMIT + 1) % WORD_W;
  localparam int AW       = $clog2(WORDS);
  localparam int LIMIT    = 2 * HALF_SUM_LIMIT;
  localparam int TW       = $clog2(LIMIT + 2);
  localparam int SW       = ((TW > ELEM_W) ? TW : ELEM_W) + 1;
  localparam word_t TOP_MASK = (TOP_BITS == 0) ? '1 : ((word_t'(1) << TOP_BITS) - word_t'(1));

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_PRE, S_SHIFT, S_DRAIN, S_SSTART, S_SRCH, S_FIN
  } state_t;

  state_t          state;
  logic [TW-1:0]   total;
  logic            ovf;
  logic            last_r;
  logic [AW-1:0]   w;
  logic [AW-1:0]   wsh_r;
  logic [BIT_W-1:0] b_r;
  logic            p1;
  logic [AW-1:0]   w_d;
  logic            alo_d;
  word_t           prev_a;
  logic [AW-1:0]   sw;
  logic [AW-1:0]   sw_d;
  logic            s1;
  logic            sfirst;
  logic            sfirst_d;
  logic [BIT_W-1:0] hb;
  logic [TW-1:0]   t;
  logic [AW-1:0]   cnt;

  // memory ports
  logic            we;
  logic [AW-1:0]   waddr;
  word_t           wdata;
  logic [AW-1:0]   raddr_a;
  word_t           rdata_a;
  word_t           rdata_b;

  // input side decode
  logic            in_xfer;
  logic [SW-1:0]   sum;
  logic [6:0]      wsh;
  logic            fits;
  logic            do_shift;
  logic            alo;
  word_t           shifted;
  word_t           masked;
  logic            found;
  logic [31:0]     diff;
  logic            out_free;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign sum      = SW'(total) + SW'(element_value);
  assign wsh      = element_value[ELEM_W-1:BIT_W];
  assign fits     = (32'(wsh) < WORDS);
  assign do_shift = !ovf && (sum <= SW'(LIMIT)) && (element_value != '0) && fits;
  assign alo      = (w == wsh_r);
  assign out_free = !out_valid || !out_stall;

  // source word read: s-1 for the word under update, preread of s at the top
  always_comb begin
    case (state)
      S_PRE:   raddr_a = AW'(WORDS - 1) - wsh_r;
      S_SHIFT: raddr_a = alo ? '0 : (w - wsh_r - AW'(1));
      S_SRCH:  raddr_a = sw;
      default: raddr_a = '0;
    endcase
  end

  // new word = old | shifted source, top word trimmed to the half-sum range
  always_comb begin
    shifted = rdata_b | (prev_a << b_r);
    if (b_r != '0 && !alo_d) shifted = shifted | (rdata_a >> (7'(WORD_W) - 7'(b_r)));
    if (w_d == AW'(WORDS - 1)) shifted = shifted & TOP_MASK;
  end

  always_comb begin
    we    = (state == S_CLR) || p1;
    waddr = (state == S_CLR) ? cnt : w_d;
    if (state == S_CLR) begin
      wdata = (cnt == '0) ? word_t'(1) : '0;
    end else begin
      wdata = shifted;
    end
  end

  // search: first word is masked to bits at or below half
  assign masked = rdata_a & (sfirst_d ? ((word_t'(2) << hb) - word_t'(1)) : '1);
  assign found  = s1 && (state == S_SRCH) && (masked != '0);
  assign diff   = 32'(total) - (32'(t) << 1);

  mpd_ram #(
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (w),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    prev_a   <= rdata_a;
    w_d      <= w;
    alo_d    <= alo;
    sw_d     <= sw;
    sfirst_d <= sfirst;
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      total     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      p1        <= 1'b0;
      s1        <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      p1 <= (state == S_SHIFT);
      s1 <= (state == S_SRCH) && !found;
      // the result load below takes over out_valid in its own cycle
      if (out_valid && !out_stall && (state != S_FIN)) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_xfer) begin
            last_r <= last_element;
            wsh_r  <= AW'(wsh);
            b_r    <= element_value[BIT_W-1:0];
            w      <= AW'(WORDS - 1);
            if (!ovf) begin
              if (sum > SW'(LIMIT)) begin
                ovf   <= 1'b1;
                total <= TW'(LIMIT + 1);
              end else begin
                total <= TW'(sum);
              end
            end
            if (do_shift) begin
              state <= S_PRE;
            end else if (last_element) begin
              // an element that pushes the total over the limit also lands here
              state <= (ovf || (sum > SW'(LIMIT))) ? S_FIN : S_SSTART;
            end
          end
        end
        S_PRE: begin
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (alo) begin
            state <= S_DRAIN;
          end else begin
            w <= w - AW'(1);
          end
        end
        S_DRAIN: begin
          state <= last_r ? S_SSTART : S_IDLE;
        end
        S_SSTART: begin
          sw     <= AW'(total >> (BIT_W + 1));
          hb     <= total[BIT_W:1];
          sfirst <= 1'b1;
          state  <= S_SRCH;
        end
        S_SRCH: begin
          sfirst <= 1'b0;
          if (sw != '0) sw <= sw - AW'(1);
          if (found) begin
            t     <= TW'({sw_d, msb_index(masked)});
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            min_difference <= ovf ? '0 : diff[ELEM_W-1:0];
            overflow       <= ovf;
            total          <= '0;
            ovf            <= 1'b0;
            cnt            <= '0;
            state          <= S_CLR;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  // no memory writes while waiting for a transfer
  `MPD_ASSERT_IMPL(a_idle_no_write, clk, rst, state == S_IDLE, !we)
  // the overflow flag always comes with a saturated total
  `MPD_ASSERT_IMPL(a_ovf_total, clk, rst, ovf, total == TW'(LIMIT + 1))
  // search pointer stays inside the memory
  `MPD_ASSERT_IMPL(a_search_range, clk, rst, state == S_SRCH, 32'(sw) < WORDS)
  // a result load is always followed by a clear sweep
  `MPD_ASSERT_NEXT(a_fin_clear, clk, rst, (state == S_FIN) && out_free, state == S_CLR)

endmodule

`default_nettype wire
